@@ hw/rtl/bc1_bc3_block_decoder_macros.svh @@
// Assertion macros used by the block decoder top level.
`ifndef BC1_BC3_BLOCK_DECODER_MACROS_SVH
`define BC1_BC3_BLOCK_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bcd_pkg.sv @@
// Types, register codes and arithmetic helpers for the block decoder.
package bcd_pkg;

    localparam int DEFAULT_MAX_SIDE = 4096;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] RESET_SIDE = 13'd4096;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } color_t;

    typedef struct packed {
        color_t [3:0]    color;
        logic [7:0][7:0] alpha;
    } palette_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } texel_t;

    // Expand a 5-bit channel to 8 bits with rounding.
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [12:0] b;
        b = 13'd16 + 13'(c) * 13'd255;
        b = b + (b >> 5);
        return b[12:5];
    endfunction

    // Expand a 6-bit channel to 8 bits with rounding.
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [13:0] b;
        b = 14'd32 + 14'(c) * 14'd255;
        b = b + (b >> 6);
        return b[13:6];
    endfunction

    // Division by three through a reciprocal; exact for inputs up to 765.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    // Division by seven through a reciprocal; exact for inputs up to 1785.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd2341;
        return p[21:14];
    endfunction

    // Division by five through a reciprocal; exact for inputs up to 1275.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd3277;
        return p[21:14];
    endfunction

    // Weighted blend (2a + b) / 3 of two 8-bit channels.
    function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
        return div3(10'({a, 1'b0}) + 10'(b));
    endfunction

endpackage

@@ hw/rtl/bcd_block_if.sv @@
// Request channel carrying one compressed block.
interface bcd_block_if;
    logic        valid;
    logic        ready;
    logic [63:0] color_block;
    logic [63:0] alpha_block;

    modport source (output valid, output color_block, output alpha_block, input ready);
    modport sink (input valid, input color_block, input alpha_block, output ready);
endinterface

@@ hw/rtl/bcd_texel_if.sv @@
// Request channel carrying one decoded texel.
interface bcd_texel_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;

    modport source (
        output valid, output pixel_x, output pixel_y, output red, output green,
        output blue, output alpha, output last, input ready
    );
    modport sink (
        input valid, input pixel_x, input pixel_y, input red, input green,
        input blue, input alpha, input last, output ready
    );
endinterface

@@ hw/rtl/bcd_palette.sv @@
// Color and alpha palette construction from the block endpoints.
module bcd_palette import bcd_pkg::*;
(
    input  logic       channel_mode,
    input  logic [15:0] color0,
    input  logic [15:0] color1,
    input  logic [7:0]  alpha0,
    input  logic [7:0]  alpha1,
    output palette_t    palette
);

    always_comb
    begin
        color_t p0;
        color_t p1;
        logic   four_color;

        p0.r = expand5(color0[15:11]);
        p0.g = expand6(color0[10:5]);
        p0.b = expand5(color0[4:0]);
        p0.a = 8'd255;
        p1.r = expand5(color1[15:11]);
        p1.g = expand6(color1[10:5]);
        p1.b = expand5(color1[4:0]);
        p1.a = 8'd255;

        four_color = channel_mode || (color0 > color1);

        palette.color[0] = p0;
        palette.color[1] = p1;
        if (four_color)
        begin
            palette.color[2].r = third(p0.r, p1.r);
            palette.color[2].g = third(p0.g, p1.g);
            palette.color[2].b = third(p0.b, p1.b);
            palette.color[2].a = 8'd255;
            palette.color[3].r = third(p1.r, p0.r);
            palette.color[3].g = third(p1.g, p0.g);
            palette.color[3].b = third(p1.b, p0.b);
            palette.color[3].a = 8'd255;
        end
        else
        begin
            palette.color[2].r = 8'((9'(p0.r) + 9'(p1.r)) >> 1);
            palette.color[2].g = 8'((9'(p0.g) + 9'(p1.g)) >> 1);
            palette.color[2].b = 8'((9'(p0.b) + 9'(p1.b)) >> 1);
            palette.color[2].a = 8'd255;
            palette.color[3]   = '0;
        end

        palette.alpha[0] = alpha0;
        palette.alpha[1] = alpha1;
        if (alpha0 > alpha1)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                palette.alpha[3'(1 + k)] = div7(11'(7 - k) * 11'(alpha0)
                                                + 11'(k) * 11'(alpha1));
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                palette.alpha[3'(1 + k)] = div5(11'(5 - k) * 11'(alpha0)
                                                + 11'(k) * 11'(alpha1));
            end
            palette.alpha[6] = 8'd0;
            palette.alpha[7] = 8'd255;
        end
    end

endmodule

@@ hw/rtl/bc1_bc3_block_decoder.sv @@
// Top level of the DXT1 / DXT5 block decoder.
//
// Blocks arrive on the blocks channel in raster block order, one 64-bit
// color block and one 64-bit alpha block per request. Each block leaves as
// its texels on the texels channel, row by row and left to right, each with
// its pixel coordinates; last marks the final texel of a block. Texels of
// edge blocks that fall outside the image are not sent.
// The configuration port sets the mode and the image size; it is to be
// written only while no block is in flight, which the block does not enforce.
// The first texel of a block passes the input register, the palette register
// and the output register before it is presented. The texel stepper emits one
// texel per cycle while the receiver does not stall; an interior block has
// sixteen texels, and a block wholly outside the image emits none.
// An input register, a palette register and the output register decouple the
// two channels, so the next block is taken while texels still wait.
// Reset empties all stages, moves the block position to the origin and sets
// DXT5 mode with a 4096 by 4096 image. A stalled receiver holds the current
// texel steady and backs pressure up to the blocks channel.
`include "bc1_bc3_block_decoder_macros.svh"

module bc1_bc3_block_decoder import bcd_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    bcd_block_if.sink                 blocks,
    bcd_texel_if.source               texels
);

    localparam int ColBits   = ((MAX_SIDE + 3) / 4 > 1) ? $clog2((MAX_SIDE + 3) / 4) : 1;
    localparam int CoordBits = ColBits + 2;
    localparam int DiffBits  = ((CoordBits > CFG_DATA_BITS) ? CoordBits : CFG_DATA_BITS) + 1;

    typedef struct packed {
        palette_t             palette;
        logic [31:0]          color_idx;
        logic [47:0]          alpha_idx;
        logic [ColBits-1:0]   col;
        logic [ColBits-1:0]   row;
        logic [1:0]           xm;
        logic [1:0]           ym;
        logic                 has_texels;
    } job_t;

    logic                     mode_reg;
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;

    logic [CFG_DATA_BITS-1:0] w_clamp;
    logic [CFG_DATA_BITS-1:0] h_clamp;
    logic [11:0]              cols;
    logic [11:0]              rows;

    logic [ColBits-1:0] col_reg;
    logic [ColBits-1:0] col_next;
    logic [ColBits-1:0] row_reg;
    logic [ColBits-1:0] row_next;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [63:0]        in_color_reg;
    logic [63:0]        in_alpha_reg;
    logic [ColBits-1:0] in_col_reg;
    logic [ColBits-1:0] in_row_reg;

    palette_t palette_comb;
    job_t     job_comb;
    job_t     pal_reg;
    logic     pal_valid_reg;
    logic     pal_valid_next;

    logic [3:0] tex_reg;
    logic [3:0] tex_next;

    texel_t out_reg;
    texel_t texel_comb;
    logic   out_valid_reg;
    logic   out_valid_next;

    logic in_accept;
    logic out_free;
    logic adv;
    logic emit;
    logic tex_last;
    logic pal_done;
    logic pal_load;

    logic [DiffBits-1:0] ox_ext;
    logic [DiffBits-1:0] oy_ext;
    logic [DiffBits-1:0] w_ext;
    logic [DiffBits-1:0] h_ext;
    logic [DiffBits-1:0] dx;
    logic [DiffBits-1:0] dy;

    logic [1:0] ci;
    logic [2:0] ai;
    color_t     sel;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            width_reg  <= RESET_SIDE;
            height_reg <= RESET_SIDE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_MODE: mode_reg   <= cfg_data[0];
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Image size limited to the supported range.
    always_comb
    begin
        if (width_reg == '0)
            w_clamp = CFG_DATA_BITS'(1);
        else if (32'(width_reg) > MAX_SIDE)
            w_clamp = CFG_DATA_BITS'(MAX_SIDE);
        else
            w_clamp = width_reg;

        if (height_reg == '0)
            h_clamp = CFG_DATA_BITS'(1);
        else if (32'(height_reg) > MAX_SIDE)
            h_clamp = CFG_DATA_BITS'(MAX_SIDE);
        else
            h_clamp = height_reg;

        cols = 12'((14'(w_clamp) + 14'd3) >> 2);
        rows = 12'((14'(h_clamp) + 14'd3) >> 2);
    end

    // Handshake and stage control.
    assign in_accept    = blocks.valid && blocks.ready;
    assign out_free     = !out_valid_reg || texels.ready;
    assign adv          = pal_valid_reg && out_free;
    assign emit         = adv && pal_reg.has_texels;
    assign tex_last     = (tex_reg[1:0] == pal_reg.xm) && (tex_reg[3:2] == pal_reg.ym);
    assign pal_done     = adv && (!pal_reg.has_texels || tex_last);
    assign pal_load     = in_valid_reg && (!pal_valid_reg || pal_done);
    assign blocks.ready = !in_valid_reg || pal_load;

    // Block position, advanced as each block is accepted.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (32'(col_reg) + 32'd1 < 32'(cols))
            begin
                col_next = col_reg + ColBits'(1);
            end
            else
            begin
                col_next = '0;
                if (32'(row_reg) + 32'd1 < 32'(rows))
                    row_next = row_reg + ColBits'(1);
                else
                    row_next = '0;
            end
        end
    end

    bcd_palette u_palette
    (
        .channel_mode (mode_reg),
        .color0       (in_color_reg[15:0]),
        .color1       (in_color_reg[31:16]),
        .alpha0       (in_alpha_reg[7:0]),
        .alpha1       (in_alpha_reg[15:8]),
        .palette      (palette_comb)
    );

    // Visible extent of the block inside the image.
    always_comb
    begin
        ox_ext = DiffBits'({in_col_reg, 2'b00});
        oy_ext = DiffBits'({in_row_reg, 2'b00});
        w_ext  = DiffBits'(w_clamp);
        h_ext  = DiffBits'(h_clamp);
        dx     = w_ext - ox_ext;
        dy     = h_ext - oy_ext;

        job_comb.palette    = palette_comb;
        job_comb.color_idx  = in_color_reg[63:32];
        job_comb.alpha_idx  = in_alpha_reg[63:16];
        job_comb.col        = in_col_reg;
        job_comb.row        = in_row_reg;
        job_comb.xm         = (dx >= DiffBits'(4)) ? 2'd3 : dx[1:0] - 2'd1;
        job_comb.ym         = (dy >= DiffBits'(4)) ? 2'd3 : dy[1:0] - 2'd1;
        job_comb.has_texels = (ox_ext < w_ext) && (oy_ext < h_ext);
    end

    // Texel selection for the current step.
    always_comb
    begin
        ci  = pal_reg.color_idx[{tex_reg, 1'b0} +: 2];
        ai  = pal_reg.alpha_idx[6'(tex_reg) * 6'd3 +: 3];
        sel = pal_reg.palette.color[ci];

        texel_comb.pixel_x = 12'({pal_reg.col, tex_reg[1:0]});
        texel_comb.pixel_y = 12'({pal_reg.row, tex_reg[3:2]});
        texel_comb.red     = sel.r;
        texel_comb.green   = sel.g;
        texel_comb.blue    = sel.b;
        texel_comb.alpha   = mode_reg ? pal_reg.palette.alpha[ai] : sel.a;
        texel_comb.last    = tex_last;
    end

    // Next state of the stage flags and the texel stepper.
    always_comb
    begin
        in_valid_next  = in_accept || (in_valid_reg && !pal_load);
        pal_valid_next = pal_load || (pal_valid_reg && !pal_done);
        out_valid_next = emit || (out_valid_reg && !texels.ready);

        tex_next = tex_reg;
        if (pal_done)
            tex_next = '0;
        else if (emit && (tex_reg[1:0] == pal_reg.xm))
            tex_next = {tex_reg[3:2] + 2'd1, 2'b00};
        else if (emit)
            tex_next = tex_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            in_valid_reg  <= 1'b0;
            pal_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            tex_reg       <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            in_valid_reg  <= in_valid_next;
            pal_valid_reg <= pal_valid_next;
            out_valid_reg <= out_valid_next;
            tex_reg       <= tex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_color_reg <= blocks.color_block;
            in_alpha_reg <= blocks.alpha_block;
            in_col_reg   <= col_reg;
            in_row_reg   <= row_reg;
        end
        if (pal_load)
            pal_reg <= job_comb;
        if (emit)
            out_reg <= texel_comb;
    end

    assign texels.valid   = out_valid_reg;
    assign texels.pixel_x = out_reg.pixel_x;
    assign texels.pixel_y = out_reg.pixel_y;
    assign texels.red     = out_reg.red;
    assign texels.green   = out_reg.green;
    assign texels.blue    = out_reg.blue;
    assign texels.alpha   = out_reg.alpha;
    assign texels.last    = out_reg.last;

    `BCD_ASSERT_SAME(a_step_in_block, pal_valid_reg && pal_reg.has_texels,
        (tex_reg[1:0] <= pal_reg.xm) && (tex_reg[3:2] <= pal_reg.ym),
        "Texel step lies outside the visible part of the block.")
    `BCD_ASSERT_SAME(a_idle_step_zero, !pal_valid_reg, tex_reg == 4'd0,
        "Texel step is not at the start while no block is held.")
    `BCD_ASSERT_NEXT(a_output_from_block,
        out_free && !(pal_valid_reg && pal_reg.has_texels), !out_valid_reg,
        "Output became valid without a block to emit from.")
    `BCD_ASSERT_NEXT(a_pending_block_moves, in_valid_reg && !pal_valid_reg, pal_valid_reg,
        "Pending block did not move into the palette stage.")

endmodule
